FILE: rtl/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

	// Field and state widths
	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int LEN_W   = 26;
	localparam int WGT_W   = 27;
	localparam int ACC_W   = 40;
	localparam int WSUM_W  = 41;
	localparam int BSUM_W  = 64;
	localparam int BEND_W  = 26;
	localparam int FRAC_W  = 17;
	localparam int CFG_W   = 26;
	localparam int BEND_FRAC = 24;

	// Shared multiplier operand width and product width
	localparam int MUL_W  = 28;
	localparam int PROD_W = 2 * MUL_W;

	// Square root works on a 52-bit radicand, two bits per step
	localparam int RAD_W      = 52;
	localparam int SQRT_STEPS = RAD_W / 2;

	// Shared divider
	localparam int DVD_W      = 78;
	localparam int DSR_W      = 52;
	localparam int QUO_W      = 27;
	localparam int BEND_STEPS = DVD_W;
	localparam int MEAN_STEPS = BSUM_W;
	localparam int CNT_W      = 7;

	localparam logic [BEND_W-1:0] BEND_MAX = BEND_W'(1) << (BEND_FRAC + 1);
	localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
	localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
	localparam logic [BSUM_W-1:0] BSUM_MAX = '1;

	// Register reset values
	localparam logic [CFG_W-1:0]  TOL_RESET   = CFG_W'(17);
	localparam logic [CFG_W-1:0]  LIMIT_RESET = CFG_W'(167772);
	localparam logic [FRAC_W-1:0] FRAC_RESET  = FRAC_W'(58982);

	// Register indexes
	localparam logic [1:0] REG_BEND_TOL   = 2'd0;
	localparam logic [1:0] REG_BEND_LIMIT = 2'd1;
	localparam logic [1:0] REG_STRAIGHT   = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ,
		S_SQRT,
		S_LEN,
		S_DOT,
		S_DEN,
		S_NUM,
		S_DIV,
		S_QUOT,
		S_WMUL,
		S_ACC,
		S_MAX,
		S_FIN,
		S_TH,
		S_TL,
		S_CMP,
		S_OUT
	} state_t;

endpackage

FILE: rtl/straight_curve_classifier.sv
`timescale 1ns / 1ps

// Straight/curve classifier for a 3D polyline.
// Input channel: one point per beat (point_x/y/z, signed with 12 fraction bits,
// last_point marks the final point). in_stall stays high while a point is in work.
// Output channel: one beat per polyline, issued after the point flagged last_point,
// carrying is_straight, total_length, longest_run, mean_bend and too_few_points.
// Work per point, from acceptance until the next point can be taken:
//   first point of a polyline: stored as the previous point
//   second point: 3 squares, 26-step square root
//   later points: squares, square root, dot product and a
//   78-step restoring division for the bend; zero-length segments skip both
//   last point adds a 64-step division for the mean bend (skipped when no
//   weight was summed) and two length-test products before the result beat.
// Products, roots and divisions share one 28x28 multiplier, one square root
// step unit and one radix-2 divider under a small sequencer.
// The result sits in an output register; while the receiver stalls a further
// result waits in the sequencer, and the block takes no new point meanwhile.
// Reset clears the curve state, loads the default thresholds and idles the block.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.

module straight_curve_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [1:0]                    cfg_index,
	input  logic [scc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [scc_pkg::COORD_W-1:0] point_x,
	input  logic signed [scc_pkg::COORD_W-1:0] point_y,
	input  logic signed [scc_pkg::COORD_W-1:0] point_z,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_straight,
	output logic [scc_pkg::ACC_W-1:0]     total_length,
	output logic [scc_pkg::ACC_W-1:0]     longest_run,
	output logic [scc_pkg::BEND_W-1:0]    mean_bend,
	output logic                          too_few_points
);

	localparam int MW = scc_pkg::MUL_W;
	localparam int PW = scc_pkg::PROD_W;

	scc_pkg::state_t state_q, state_d;

	// Configuration registers
	logic [scc_pkg::CFG_W-1:0]  tol_q, limit_q;
	logic [scc_pkg::FRAC_W-1:0] frac_q;

	// Curve state
	logic signed [scc_pkg::COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [scc_pkg::DIFF_W-1:0]  seg_dx_q, seg_dy_q, seg_dz_q;
	logic [scc_pkg::LEN_W-1:0]  seg_len_q;
	logic [1:0]                 pts_q;
	logic [scc_pkg::ACC_W-1:0]  run_q, total_q, max_run_q;
	logic [scc_pkg::BSUM_W-1:0] bsum_q;
	logic [scc_pkg::WSUM_W-1:0] wsum_q;

	// Working registers
	logic signed [scc_pkg::DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic                       last_q;
	logic [scc_pkg::CNT_W-1:0]  cnt_q;
	logic signed [PW-1:0]       acc_q;
	logic [scc_pkg::RAD_W-1:0]  rad_q;
	logic [scc_pkg::LEN_W+1:0]  rem_q;
	logic [scc_pkg::LEN_W-1:0]  root_q;
	logic [scc_pkg::DSR_W-1:0]  den_q;
	logic [scc_pkg::DVD_W-1:0]  dvd_q;
	logic [scc_pkg::DSR_W-1:0]  dsr_q;
	logic [scc_pkg::DSR_W-1:0]  drem_q;
	logic [scc_pkg::QUO_W-1:0]  quo_q;
	logic                       ovf_q;
	logic                       div_mean_q;
	logic [scc_pkg::BEND_W-1:0] bend_q;
	logic [scc_pkg::BEND_W-1:0] mean_q;
	logic [52:0]                wprod_q;
	logic [40:0]                p_hi_q;
	logic [32:0]                p_lo_q;
	logic                       straight_q;

	// Output register
	logic                       out_valid_q;
	logic                       o_straight_q, o_few_q;
	logic [scc_pkg::ACC_W-1:0]  o_total_q, o_run_q;
	logic [scc_pkg::BEND_W-1:0] o_mean_q;

	logic in_take, out_free, few;
	logic [1:0] k;
	logic signed [scc_pkg::DIFF_W-1:0] d_k, seg_k;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] acc_next;
	logic [scc_pkg::LEN_W+3:0] sq_try, sq_trial;
	logic sq_ge;
	logic [scc_pkg::DSR_W:0] dv_try;
	logic dv_ge;
	logic [scc_pkg::BEND_W-1:0] quo_clamp;
	logic signed [PW-1:0] num;
	logic num_pos;
	logic [scc_pkg::WGT_W-1:0] weight;
	logic [scc_pkg::ACC_W-1:0] run_base;
	logic [scc_pkg::ACC_W:0] run_sum, total_sum;
	logic [scc_pkg::BSUM_W:0] bsum_sum;
	logic [scc_pkg::WSUM_W:0] wsum_sum;
	logic [scc_pkg::BEND_W-1:0] bsum_clamp;
	logic [55:0] need_lhs;
	logic [56:0] need_rhs;
	logic last_step;

	function automatic logic signed [scc_pkg::DIFF_W-1:0] coord_diff(
		input logic signed [scc_pkg::COORD_W-1:0] a,
		input logic signed [scc_pkg::COORD_W-1:0] b
	);
		coord_diff = scc_pkg::DIFF_W'(a) - scc_pkg::DIFF_W'(b);
	endfunction

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != scc_pkg::S_IDLE);
	assign few      = (pts_q < 2'd2);
	assign k        = cnt_q[1:0];

	// Select the current difference component and segment component
	always_comb begin
		case (k)
			2'd0: begin d_k = dx_q; seg_k = seg_dx_q; end
			2'd1: begin d_k = dy_q; seg_k = seg_dy_q; end
			default: begin d_k = dz_q; seg_k = seg_dz_q; end
		endcase
	end

	assign weight = {1'b0, seg_len_q} + {1'b0, root_q};

	// Feed the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			scc_pkg::S_SQ: begin
				mul_a = MW'(d_k);
				mul_b = MW'(d_k);
			end
			scc_pkg::S_DOT: begin
				mul_a = MW'(seg_k);
				mul_b = MW'(d_k);
			end
			scc_pkg::S_DEN: begin
				mul_a = signed'(MW'(seg_len_q));
				mul_b = signed'(MW'(root_q));
			end
			scc_pkg::S_WMUL: begin
				mul_a = signed'(MW'(bend_q));
				mul_b = signed'(MW'(weight));
			end
			scc_pkg::S_TH: begin
				mul_a = signed'(MW'(total_q[scc_pkg::ACC_W-1:16]));
				mul_b = signed'(MW'(frac_q));
			end
			scc_pkg::S_TL: begin
				mul_a = signed'(MW'(total_q[15:0]));
				mul_b = signed'(MW'(frac_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign acc_next = ((k == 2'd0) ? PW'(0) : acc_q) + prod;

	// Square root step: bring down two radicand bits
	assign sq_try   = {rem_q, rad_q[scc_pkg::RAD_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_try >= sq_trial);

	// Divider step: bring down one dividend bit
	assign dv_try = {drem_q, dvd_q[scc_pkg::DVD_W-1]};
	assign dv_ge  = (dv_try >= {1'b0, dsr_q});
	assign last_step = div_mean_q ? (cnt_q == scc_pkg::CNT_W'(scc_pkg::MEAN_STEPS - 1))
	                              : (cnt_q == scc_pkg::CNT_W'(scc_pkg::BEND_STEPS - 1));
	assign quo_clamp = (ovf_q || (quo_q > scc_pkg::QUO_W'(scc_pkg::BEND_MAX)))
		? scc_pkg::BEND_MAX : quo_q[scc_pkg::BEND_W-1:0];

	assign num     = signed'(PW'(den_q)) - acc_q;
	assign num_pos = !num[PW-1] && (num != '0);

	// Accumulator updates
	assign run_base  = (32'(bend_q) > 32'(tol_q)) ? '0 : run_q;
	assign run_sum   = {1'b0, run_base} + (scc_pkg::ACC_W+1)'(root_q);
	assign total_sum = {1'b0, total_q} + (scc_pkg::ACC_W+1)'(root_q);
	assign bsum_sum  = {1'b0, bsum_q} + (scc_pkg::BSUM_W+1)'(wprod_q);
	assign wsum_sum  = {1'b0, wsum_q} + (scc_pkg::WSUM_W+1)'(weight);
	assign bsum_clamp = (bsum_q > scc_pkg::BSUM_W'(scc_pkg::BEND_MAX))
		? scc_pkg::BEND_MAX : bsum_q[scc_pkg::BEND_W-1:0];

	// Exact length test: max_run * 2^16 < total * fraction
	assign need_lhs = {max_run_q, 16'b0};
	assign need_rhs = {p_hi_q, 16'b0} + 57'(p_lo_q);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the shared units
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::S_IDLE: begin
				if (in_take) state_d = (pts_q == 2'd0) ? scc_pkg::S_FIN : scc_pkg::S_SQ;
			end
			scc_pkg::S_SQ: begin
				if (k == 2'd2) state_d = scc_pkg::S_SQRT;
			end
			scc_pkg::S_SQRT: begin
				if (cnt_q == scc_pkg::CNT_W'(scc_pkg::SQRT_STEPS - 1)) state_d = scc_pkg::S_LEN;
			end
			scc_pkg::S_LEN: begin
				if (pts_q == 2'd1) state_d = scc_pkg::S_FIN;
				else if (seg_len_q == '0 || root_q == '0) state_d = scc_pkg::S_WMUL;
				else state_d = scc_pkg::S_DOT;
			end
			scc_pkg::S_DOT: begin
				if (k == 2'd2) state_d = scc_pkg::S_DEN;
			end
			scc_pkg::S_DEN:  state_d = scc_pkg::S_NUM;
			scc_pkg::S_NUM:  state_d = num_pos ? scc_pkg::S_DIV : scc_pkg::S_WMUL;
			scc_pkg::S_DIV: begin
				if (last_step) state_d = scc_pkg::S_QUOT;
			end
			scc_pkg::S_QUOT: state_d = div_mean_q ? scc_pkg::S_TH : scc_pkg::S_WMUL;
			scc_pkg::S_WMUL: state_d = scc_pkg::S_ACC;
			scc_pkg::S_ACC:  state_d = scc_pkg::S_MAX;
			scc_pkg::S_MAX:  state_d = scc_pkg::S_FIN;
			scc_pkg::S_FIN: begin
				if (!last_q) state_d = scc_pkg::S_IDLE;
				else if (wsum_q != '0) state_d = scc_pkg::S_DIV;
				else state_d = scc_pkg::S_TH;
			end
			scc_pkg::S_TH:  state_d = scc_pkg::S_TL;
			scc_pkg::S_TL:  state_d = scc_pkg::S_CMP;
			scc_pkg::S_CMP: state_d = scc_pkg::S_OUT;
			scc_pkg::S_OUT: begin
				if (out_free) state_d = scc_pkg::S_IDLE;
			end
			default: state_d = scc_pkg::S_IDLE;
		endcase
	end

	// Hold configuration and curve state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= scc_pkg::TOL_RESET;
			limit_q   <= scc_pkg::LIMIT_RESET;
			frac_q    <= scc_pkg::FRAC_RESET;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			prev_z_q  <= '0;
			seg_dx_q  <= '0;
			seg_dy_q  <= '0;
			seg_dz_q  <= '0;
			seg_len_q <= '0;
			pts_q     <= '0;
			run_q     <= '0;
			total_q   <= '0;
			max_run_q <= '0;
			bsum_q    <= '0;
			wsum_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					scc_pkg::REG_BEND_TOL:   tol_q   <= cfg_data;
					scc_pkg::REG_BEND_LIMIT: limit_q <= cfg_data;
					scc_pkg::REG_STRAIGHT:   frac_q  <= cfg_data[scc_pkg::FRAC_W-1:0];
					default: ;
				endcase
			end
			// Raise the result beat or drop it once taken
			if (state_q == scc_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				scc_pkg::S_IDLE: begin
					if (in_take) begin
						prev_x_q <= point_x;
						prev_y_q <= point_y;
						prev_z_q <= point_z;
						if (pts_q == 2'd0) pts_q <= 2'd1;
					end
				end
				scc_pkg::S_LEN: begin
					if (pts_q == 2'd1) begin
						seg_dx_q  <= dx_q;
						seg_dy_q  <= dy_q;
						seg_dz_q  <= dz_q;
						seg_len_q <= root_q;
						run_q     <= scc_pkg::ACC_W'(root_q);
						total_q   <= scc_pkg::ACC_W'(root_q);
						max_run_q <= scc_pkg::ACC_W'(root_q);
						pts_q     <= 2'd2;
					end
				end
				scc_pkg::S_ACC: begin
					run_q   <= run_sum[scc_pkg::ACC_W] ? scc_pkg::ACC_MAX
					                                   : run_sum[scc_pkg::ACC_W-1:0];
					total_q <= total_sum[scc_pkg::ACC_W] ? scc_pkg::ACC_MAX
					                                     : total_sum[scc_pkg::ACC_W-1:0];
					bsum_q  <= bsum_sum[scc_pkg::BSUM_W] ? scc_pkg::BSUM_MAX
					                                     : bsum_sum[scc_pkg::BSUM_W-1:0];
					wsum_q  <= wsum_sum[scc_pkg::WSUM_W] ? scc_pkg::WSUM_MAX
					                                     : wsum_sum[scc_pkg::WSUM_W-1:0];
					seg_dx_q  <= dx_q;
					seg_dy_q  <= dy_q;
					seg_dz_q  <= dz_q;
					seg_len_q <= root_q;
				end
				scc_pkg::S_MAX: begin
					if (run_q > max_run_q) max_run_q <= run_q;
				end
				scc_pkg::S_OUT: begin
					// Start a new polyline once the result beat is issued
					if (out_free) begin
						prev_x_q  <= '0;
						prev_y_q  <= '0;
						prev_z_q  <= '0;
						seg_dx_q  <= '0;
						seg_dy_q  <= '0;
						seg_dz_q  <= '0;
						seg_len_q <= '0;
						pts_q     <= '0;
						run_q     <= '0;
						total_q   <= '0;
						max_run_q <= '0;
						bsum_q    <= '0;
						wsum_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		case (state_q)
			scc_pkg::S_IDLE: begin
				if (in_take) begin
					dx_q   <= coord_diff(point_x, prev_x_q);
					dy_q   <= coord_diff(point_y, prev_y_q);
					dz_q   <= coord_diff(point_z, prev_z_q);
					last_q <= last_point;
					cnt_q  <= '0;
					bend_q <= '0;
					wprod_q <= '0;
				end
			end
			scc_pkg::S_SQ: begin
				acc_q <= acc_next;
				if (k == 2'd2) begin
					rad_q  <= acc_next[scc_pkg::RAD_W-1:0];
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			scc_pkg::S_SQRT: begin
				rad_q <= rad_q << 2;
				if (sq_ge) begin
					rem_q  <= (scc_pkg::LEN_W+2)'(sq_try - sq_trial);
					root_q <= {root_q[scc_pkg::LEN_W-2:0], 1'b1};
				end else begin
					rem_q  <= (scc_pkg::LEN_W+2)'(sq_try);
					root_q <= {root_q[scc_pkg::LEN_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			scc_pkg::S_LEN: begin
				cnt_q  <= '0;
				bend_q <= '0;
			end
			scc_pkg::S_DOT: begin
				acc_q <= acc_next;
				cnt_q <= cnt_q + 1'b1;
			end
			scc_pkg::S_DEN: begin
				den_q <= prod[scc_pkg::DSR_W-1:0];
			end
			scc_pkg::S_NUM: begin
				// Load the divider with num * 2^24 over den
				dvd_q      <= {1'b0, num[52:0], {scc_pkg::BEND_FRAC{1'b0}}};
				dsr_q      <= den_q;
				drem_q     <= '0;
				quo_q      <= '0;
				ovf_q      <= 1'b0;
				div_mean_q <= 1'b0;
				cnt_q      <= '0;
				bend_q     <= '0;
			end
			scc_pkg::S_DIV: begin
				dvd_q  <= dvd_q << 1;
				drem_q <= dv_ge ? scc_pkg::DSR_W'(dv_try - {1'b0, dsr_q})
				                : dv_try[scc_pkg::DSR_W-1:0];
				quo_q  <= {quo_q[scc_pkg::QUO_W-2:0], dv_ge};
				if (quo_q[scc_pkg::QUO_W-1]) ovf_q <= 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end
			scc_pkg::S_QUOT: begin
				if (div_mean_q) mean_q <= quo_clamp;
				else bend_q <= quo_clamp;
			end
			scc_pkg::S_WMUL: begin
				wprod_q <= prod[52:0];
			end
			scc_pkg::S_FIN: begin
				mean_q     <= bsum_clamp;
				dvd_q      <= {bsum_q, {(scc_pkg::DVD_W - scc_pkg::BSUM_W){1'b0}}};
				dsr_q      <= scc_pkg::DSR_W'(wsum_q);
				drem_q     <= '0;
				quo_q      <= '0;
				ovf_q      <= 1'b0;
				div_mean_q <= 1'b1;
				cnt_q      <= '0;
			end
			scc_pkg::S_TH: begin
				p_hi_q <= prod[40:0];
			end
			scc_pkg::S_TL: begin
				p_lo_q <= prod[32:0];
			end
			scc_pkg::S_CMP: begin
				straight_q <= few || !(56'(need_lhs) < need_rhs[55:0] || need_rhs[56])
				              || !(mean_q > limit_q);
			end
			scc_pkg::S_OUT: begin
				if (out_free) begin
					o_straight_q <= straight_q;
					o_total_q    <= total_q;
					o_run_q      <= max_run_q;
					o_mean_q     <= mean_q;
					o_few_q      <= few;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign is_straight    = o_straight_q;
	assign total_length   = o_total_q;
	assign longest_run    = o_run_q;
	assign mean_bend      = o_mean_q;
	assign too_few_points = o_few_q;

	// Checks on the sequencer and the result beat
	a_pts_range: assert property (@(posedge clk) disable iff (!arst_n)
		pts_q != 2'd3)
		else $error("point count out of range");

	a_mean_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mean_bend <= scc_pkg::BEND_MAX)
		else $error("mean bend above clamp");

	a_run_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> longest_run <= total_length)
		else $error("longest run exceeds total length");

	a_few_straight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_few_points |-> is_straight && total_length == '0)
		else $error("short polyline not reported straight and empty");

endmodule

FILE: tb/straight_curve_classifier_tb.sv
`timescale 1ns / 1ps

module straight_curve_classifier_tb;

	typedef struct {
		logic             straight;
		logic [scc_pkg::ACC_W-1:0] total;
		logic [scc_pkg::ACC_W-1:0] run;
		logic [scc_pkg::BEND_W-1:0] mean;
		logic             few;
	} verdict_t;

	typedef struct {
		int       x;
		int       y;
		int       z;
		bit       last;
		bit       typed;
		verdict_t want;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [scc_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [scc_pkg::COORD_W-1:0] point_x;
	logic signed [scc_pkg::COORD_W-1:0] point_y;
	logic signed [scc_pkg::COORD_W-1:0] point_z;
	logic last_point;
	logic out_valid;
	logic out_stall;
	logic is_straight;
	logic [scc_pkg::ACC_W-1:0] total_length;
	logic [scc_pkg::ACC_W-1:0] longest_run;
	logic [scc_pkg::BEND_W-1:0] mean_bend;
	logic too_few_points;

	straight_curve_classifier uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z), .last_point(last_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_straight(is_straight), .total_length(total_length), .longest_run(longest_run),
		.mean_bend(mean_bend), .too_few_points(too_few_points)
	);

	localparam logic [63:0] ACC_TOP  = (64'd1 << 40) - 1;
	localparam logic [63:0] WSUM_TOP = (64'd1 << 41) - 1;
	localparam logic [63:0] BSUM_TOP = '1;
	localparam logic [63:0] BEND_TOP = 64'd1 << 25;

	// Thresholds as the block should hold them
	logic [63:0] tol_q, limit_q, frac_q;
	// Curve state of the shadow classifier
	longint px, py, pz, sdx, sdy, sdz;
	logic [63:0] slen, run_acc, total_acc, max_acc, bsum_acc, wsum_acc;
	int npts;

	verdict_t verdicts_due[$];
	int errors;
	int items_sent;
	int out_hold;
	bit long_hold_req;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[straight_curve_classifier] ERROR");
		$finish;
	end

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] top);
		if (a > top) a = top;
		if (b > top - a) return top;
		return a + b;
	endfunction

	function automatic logic [63:0] span_len(longint dx, longint dy, longint dz);
		logic [63:0] ax, ay, az;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		return int_sqrt(ax * ax + ay * ay + az * az);
	endfunction

	// One minus cosine between the held segment and the new one, Q2.24
	function automatic logic [63:0] turn_of(longint dx, longint dy, longint dz,
			logic [63:0] len1);
		longint dot, num;
		logic [63:0] den, q, r;
		if (slen == 0 || len1 == 0) return 0;
		dot = sdx * dx + sdy * dy + sdz * dz;
		den = slen * len1;
		num = longint'(den) - dot;
		if (num <= 0) return 0;
		q = num / den;
		r = num % den;
		for (int i = 0; i < scc_pkg::BEND_FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q > BEND_TOP ? BEND_TOP : q;
	endfunction

	function automatic void clear_polyline();
		px = 0; py = 0; pz = 0;
		sdx = 0; sdy = 0; sdz = 0;
		slen = 0; npts = 0;
		run_acc = 0; total_acc = 0; max_acc = 0;
		bsum_acc = 0; wsum_acc = 0;
	endfunction

	// Advance the shadow classifier by one point; return 1 with a verdict on the last one
	function automatic bit classify_point(longint x, longint y, longint z, bit last,
			output verdict_t v);
		longint dx, dy, dz;
		logic [63:0] len1, turn, weight, mean, th, tl, need;
		bit few, straight;
		if (npts == 1) begin
			sdx = x - px; sdy = y - py; sdz = z - pz;
			slen = span_len(sdx, sdy, sdz);
			run_acc = slen > ACC_TOP ? ACC_TOP : slen;
			total_acc = run_acc;
			max_acc = run_acc;
			npts = 2;
		end else if (npts >= 2) begin
			dx = x - px; dy = y - py; dz = z - pz;
			len1 = span_len(dx, dy, dz);
			turn = turn_of(dx, dy, dz, len1);
			weight = slen + len1;
			if (turn > tol_q) run_acc = 0;
			run_acc = sat_sum(run_acc, len1, ACC_TOP);
			total_acc = sat_sum(total_acc, len1, ACC_TOP);
			bsum_acc = sat_sum(bsum_acc, turn * weight, BSUM_TOP);
			wsum_acc = sat_sum(wsum_acc, weight, WSUM_TOP);
			if (run_acc > max_acc) max_acc = run_acc;
			sdx = dx; sdy = dy; sdz = dz;
			slen = len1;
		end else begin
			npts = 1;
		end
		px = x; py = y; pz = z;
		if (!last) return 0;
		mean = wsum_acc != 0 ? bsum_acc / wsum_acc : bsum_acc;
		th = total_acc >> 16;
		tl = total_acc & 64'hFFFF;
		need = th * frac_q + ((tl * frac_q + 64'hFFFF) >> 16);
		few = npts < 2;
		straight = 1'b1;
		if (mean > BEND_TOP) mean = BEND_TOP;
		if (!few && max_acc < need && mean > limit_q) straight = 1'b0;
		v.straight = straight;
		v.total = total_acc[scc_pkg::ACC_W-1:0];
		v.run = max_acc[scc_pkg::ACC_W-1:0];
		v.mean = mean[scc_pkg::BEND_W-1:0];
		v.few = few;
		clear_polyline();
		return 1;
	endfunction

	// Write one threshold while the block is idle
	task automatic write_reg(logic [1:0] idx, logic [scc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == scc_pkg::REG_BEND_TOL) tol_q = val;
		else if (idx == scc_pkg::REG_BEND_LIMIT) limit_q = val;
		else if (idx == scc_pkg::REG_STRAIGHT) frac_q = val & 26'h1FFFF;
	endtask

	// Offer one point beat, wait for it to be taken, queue its verdict
	task automatic send_point(int x, int y, int z, bit last, bit typed, verdict_t want);
		verdict_t v;
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x[scc_pkg::COORD_W-1:0];
		point_y <= y[scc_pkg::COORD_W-1:0];
		point_z <= z[scc_pkg::COORD_W-1:0];
		last_point <= last;
		do @(posedge clk); while (!(in_valid && !in_stall));
		if (classify_point(longint'(point_x), longint'(point_y), longint'(point_z), last, v))
		begin
			if (typed) v = want;
			verdicts_due.insert(verdicts_due.size(), v);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (verdicts_due.size() == 0);
		repeat (300) @(negedge clk);
	endtask

	// One random polyline: mostly near-straight, some curled, some scattered
	task automatic send_polyline();
		int n, kind, x, y, z, vx, vy, vz, nz;
		verdict_t none;
		none = '{default: 0};
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 7);
		kind = $urandom_range(0, 9);
		x = $urandom_range(0, 2097152) - 1048576;
		y = $urandom_range(0, 2097152) - 1048576;
		z = $urandom_range(0, 2097152) - 1048576;
		vx = $urandom_range(0, 16384) - 8192;
		vy = $urandom_range(0, 16384) - 8192;
		vz = $urandom_range(0, 16384) - 8192;
		nz = 1 << $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			if (kind >= 8) begin
				x = $urandom(); y = $urandom(); z = $urandom();
			end else begin
				if (kind >= 6) begin
					vx += $urandom_range(0, 8192) - 4096;
					vz += $urandom_range(0, 8192) - 4096;
				end
				x += vx + $urandom_range(0, nz) - nz / 2;
				y += vy + $urandom_range(0, nz) - nz / 2;
				z += vz + $urandom_range(0, nz) - nz / 2;
			end
			send_point(x, y, z, i == n - 1, 1'b0, none);
		end
	endtask

	point_row_t dir_rows[19] = '{
		'{0, 0, 0, 1, 1, '{1, 0, 0, 0, 1}},
		'{8388607, 8388607, 8388607, 1, 1, '{1, 0, 0, 0, 1}},
		'{0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{4096, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{8192, 0, 0, 1, 1, '{1, 8192, 8192, 0, 0}},
		'{100, 100, 100, 0, 0, '{0, 0, 0, 0, 0}},
		'{100, 100, 100, 0, 0, '{0, 0, 0, 0, 0}},
		'{500, 100, 100, 1, 1, '{1, 400, 400, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{4096, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{0, 0, 0, 1, 1, '{0, 8192, 4096, 33554432, 0}},
		'{-8388608, -8388608, -8388608, 0, 0, '{0, 0, 0, 0, 0}},
		'{8388607, 8388607, 8388607, 0, 0, '{0, 0, 0, 0, 0}},
		'{-8388608, 8388607, -8388608, 1, 0, '{0, 0, 0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{0, 4096, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{0, 4096, 4096, 1, 0, '{0, 0, 0, 0, 0}},
		'{1, -1, 1, 0, 0, '{0, 0, 0, 0, 0}},
		'{-2, 2, -2, 1, 0, '{0, 0, 0, 0, 0}}
	};

	// Receiver: random holds per beat, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		out_hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_hold = 3000;
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each result beat against the oldest verdict
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("unexpected beat", 0, 0);
			end else begin
				w = verdicts_due.pop_front();
				if (is_straight !== w.straight) report_mismatch("is_straight", is_straight, w.straight);
				if (total_length !== w.total) report_mismatch("total_length", total_length, w.total);
				if (longest_run !== w.run) report_mismatch("longest_run", longest_run, w.run);
				if (mean_bend !== w.mean) report_mismatch("mean_bend", mean_bend, w.mean);
				if (too_few_points !== w.few)
					report_mismatch("too_few_points", too_few_points, w.few);
			end
			out_hold = idle_on ? $urandom_range(0, 13) : 0;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		long_hold_req = 1'b0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = scc_pkg::REG_BEND_TOL;
		cfg_data = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		last_point = 1'b0;
		tol_q = scc_pkg::TOL_RESET;
		limit_q = scc_pkg::LIMIT_RESET;
		frac_q = scc_pkg::FRAC_RESET;
		clear_polyline();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points under the reset thresholds
		foreach (dir_rows[i])
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last,
				dir_rows[i].typed, dir_rows[i].want);
		settle();

		// Random polylines over several threshold settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					write_reg(scc_pkg::REG_BEND_TOL, '0);
					write_reg(scc_pkg::REG_BEND_LIMIT, '0);
					write_reg(scc_pkg::REG_STRAIGHT, '0);
				end
				2: begin
					write_reg(scc_pkg::REG_BEND_TOL, scc_pkg::CFG_W'(33554432));
					write_reg(scc_pkg::REG_BEND_LIMIT, scc_pkg::CFG_W'(33554432));
					write_reg(scc_pkg::REG_STRAIGHT, scc_pkg::CFG_W'(65536));
					long_hold_req = 1'b1;
				end
				3: begin
					write_reg(scc_pkg::REG_BEND_TOL, '1);
					write_reg(scc_pkg::REG_BEND_LIMIT, '1);
					write_reg(scc_pkg::REG_STRAIGHT, '1);
					write_reg(2'd3, '1);
				end
				4, 5: begin
					write_reg(scc_pkg::REG_BEND_TOL,
						scc_pkg::CFG_W'($urandom_range(0, 1 << 20)));
					write_reg(scc_pkg::REG_BEND_LIMIT,
						scc_pkg::CFG_W'($urandom_range(0, 1 << 22)));
					write_reg(scc_pkg::REG_STRAIGHT,
						scc_pkg::CFG_W'($urandom_range(0, 65536)));
				end
				default: ;
			endcase
			idle_on = (ph != 3);
			while (items_sent < 19 + 72 * (ph + 1)) begin
				// drain everything before some polylines
				if ($urandom_range(0, 11) == 0) begin
					@(negedge clk);
					in_valid <= 1'b0;
					wait (verdicts_due.size() == 0);
					@(negedge clk);
				end
				send_polyline();
			end
			settle();
		end

		if (errors == 0) begin
			$display("[straight_curve_classifier] OK");
		end else begin
			$display("[straight_curve_classifier] ERROR");
		end
		$finish;
	end

endmodule
